@@ hdl/ilw_pkg.sv @@
// Shared constants, types and codes of the interpolated curve waveshaper.
package ilw_pkg;

  // Number of curve table entries, and the widths that follow from it.
  localparam int TABLE_ENTRIES = 257;
  localparam int TBL_LAST      = TABLE_ENTRIES - 1;
  localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
  localparam int IDXH_W        = TBL_AW + 2;

  // Fixed-point formats.
  localparam int FRAC_BITS = 15;
  localparam int MAG_W     = 17;
  localparam int VAL_W     = 16;
  localparam int POS_W     = MAG_W + TBL_AW;
  localparam int PROD_W    = 33;
  localparam int SUM_W     = 18;

  localparam logic [MAG_W-1:0] ONE_Q15 = MAG_W'(32768);

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Word leaving the scaling stages toward the table.
  typedef struct packed {
    logic                  is_sample;
    logic                  wen;
    logic [TBL_AW-1:0]     waddr;
    logic [VAL_W-1:0]      wdata;
    logic [TBL_AW-1:0]     idx0;
    logic [TBL_AW-1:0]     idx1;
    logic [FRAC_BITS-1:0]  frac;
    logic                  neg;
  } scale_word_t;

  // Word leaving the table stage toward the interpolator.
  typedef struct packed {
    logic [VAL_W-1:0]      t0;
    logic [VAL_W-1:0]      t1;
    logic [FRAC_BITS-1:0]  frac;
    logic                  neg;
  } tbl_word_t;

endpackage

@@ hdl/ilw_scale.sv @@
// Clamp, magnitude and table position stages of the waveshaper.
module ilw_scale
  import ilw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  output logic                 up_rdy,
  input  logic                 cmd,
  input  logic [8:0]           table_index,
  input  logic [VAL_W-1:0]     table_value,
  input  logic signed [17:0]   sample_in,
  output logic                 dn_valid,
  input  logic                 dn_rdy,
  output scale_word_t          dn_word
);

  localparam logic [IDXH_W-1:0] LAST_HI  = IDXH_W'(TBL_LAST);
  localparam logic [TBL_AW-1:0] LAST_IDX = TBL_AW'(TBL_LAST);
  localparam logic [TBL_AW-1:0] SCALE    = TBL_AW'(TBL_LAST);

  // First stage: clamped magnitude and load fields.
  logic                 v1_r, v1_nxt;
  logic                 smp1_r, wen1_r;
  logic [TBL_AW-1:0]    waddr1_r;
  logic [VAL_W-1:0]     wdata1_r;
  logic [MAG_W-1:0]     mag1_r;
  logic                 neg1_r;

  // Second stage: table position.
  logic                 v2_r, v2_nxt;
  scale_word_t          w2_r;

  logic                 rdy1, rdy2;
  logic [31:0]          tidx_ext;
  logic                 wen_c;
  logic signed [17:0]   abs_c;
  logic [MAG_W-1:0]     mag_c;
  logic [POS_W-1:0]     pos_c;
  logic [IDXH_W-1:0]    idx_hi_c;
  logic [TBL_AW-1:0]    idx0_c, idx1_c;
  scale_word_t          w2_nxt;

  assign rdy2   = !v2_r || dn_rdy;
  assign rdy1   = !v1_r || rdy2;
  assign up_rdy = rdy1;

  always_comb begin
    tidx_ext = 32'(table_index);
    wen_c    = (cmd == CMD_LOAD) && (tidx_ext < 32'(TABLE_ENTRIES));
    abs_c    = sample_in[17] ? -sample_in : sample_in;
    if (sample_in > 18'sd32768 || sample_in < -18'sd32768) begin
      mag_c = ONE_Q15;
    end else begin
      mag_c = abs_c[MAG_W-1:0];
    end
    v1_nxt = rdy1 ? up_valid : v1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
    if (rdy1) begin
      smp1_r   <= (cmd == CMD_SAMPLE);
      wen1_r   <= wen_c;
      waddr1_r <= tidx_ext[TBL_AW-1:0];
      wdata1_r <= table_value;
      mag1_r   <= mag_c;
      neg1_r   <= sample_in[17];
    end
  end

  // Position = magnitude * (entries - 1); the integer part is the index.
  always_comb begin
    pos_c    = POS_W'(mag1_r) * POS_W'(SCALE);
    idx_hi_c = pos_c[POS_W-1:FRAC_BITS];
    idx0_c   = (idx_hi_c >= LAST_HI) ? LAST_IDX : idx_hi_c[TBL_AW-1:0];
    idx1_c   = (idx0_c == LAST_IDX) ? LAST_IDX : idx0_c + TBL_AW'(1);
    w2_nxt.is_sample = smp1_r;
    w2_nxt.wen       = wen1_r;
    w2_nxt.waddr     = waddr1_r;
    w2_nxt.wdata     = wdata1_r;
    w2_nxt.idx0      = idx0_c;
    w2_nxt.idx1      = idx1_c;
    w2_nxt.frac      = pos_c[FRAC_BITS-1:0];
    w2_nxt.neg       = neg1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
    end
    if (rdy2) begin
      w2_r <= w2_nxt;
    end
  end

  assign dn_valid = v2_r;
  assign dn_word  = w2_r;

endmodule

@@ hdl/ilw_table.sv @@
// Curve table memory stage: writes load words and reads both neighbors for samples.
module ilw_table
  import ilw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_rdy,
  input  scale_word_t up_word,
  output logic        dn_valid,
  input  logic        dn_rdy,
  output tbl_word_t   dn_word
);

  logic [VAL_W-1:0]     mem_r [TABLE_ENTRIES];
  logic                 v3_r, v3_nxt;
  logic [VAL_W-1:0]     t0_r, t1_r;
  logic [FRAC_BITS-1:0] frac3_r;
  logic                 neg3_r;
  logic                 rdy3, adv;

  assign rdy3   = !v3_r || dn_rdy;
  assign up_rdy = rdy3;
  assign adv    = rdy3 && up_valid;

  // Load words write here and then leave the pipeline.
  always_comb begin
    v3_nxt = rdy3 ? (up_valid && up_word.is_sample) : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_word.wen) begin
      mem_r[up_word.waddr] <= up_word.wdata;
    end
    if (rdy3) begin
      t0_r    <= mem_r[up_word.idx0];
      t1_r    <= mem_r[up_word.idx1];
      frac3_r <= up_word.frac;
      neg3_r  <= up_word.neg;
    end
  end

  assign dn_valid     = v3_r;
  assign dn_word.t0   = t0_r;
  assign dn_word.t1   = t1_r;
  assign dn_word.frac = frac3_r;
  assign dn_word.neg  = neg3_r;

endmodule

@@ hdl/ilw_interp.sv @@
// Linear interpolation, saturation and sign restore stages, ending in the output register.
module ilw_interp
  import ilw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_rdy,
  input  tbl_word_t               up_word,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MAG_W-1:0] out_sample
);

  logic                     v4_r, v4_nxt;
  logic signed [PROD_W-1:0] prod4_r;
  logic [VAL_W-1:0]         t04_r;
  logic                     neg4_r;

  logic                     v5_r, v5_nxt;
  logic signed [MAG_W-1:0]  res5_r;

  logic                     rdy4, rdy5;
  logic signed [MAG_W-1:0]  diff_c;
  logic signed [VAL_W-1:0]  frac_s;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [SUM_W-1:0]  t0_s, step_s, sum_c;
  logic [MAG_W-1:0]         mag_c;
  logic signed [MAG_W-1:0]  res_c;

  assign rdy5   = !v5_r || !out_stall;
  assign rdy4   = !v4_r || rdy5;
  assign up_rdy = rdy4;

  // Slope times fraction; the fraction is a non-negative 15-bit value.
  always_comb begin
    diff_c = $signed({1'b0, up_word.t1}) - $signed({1'b0, up_word.t0});
    frac_s = $signed({1'b0, up_word.frac});
    prod_c = PROD_W'(diff_c) * PROD_W'(frac_s);
    v4_nxt = rdy4 ? up_valid : v4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v4_nxt;
    end
    if (rdy4) begin
      prod4_r <= prod_c;
      t04_r   <= up_word.t0;
      neg4_r  <= up_word.neg;
    end
  end

  // The arithmetic shift floors the step toward minus infinity.
  always_comb begin
    t0_s   = $signed({2'b00, t04_r});
    step_s = prod4_r[PROD_W-1:FRAC_BITS];
    sum_c  = t0_s + step_s;
    if (sum_c > $signed({1'b0, ONE_Q15})) begin
      mag_c = ONE_Q15;
    end else if (sum_c < 0) begin
      mag_c = '0;
    end else begin
      mag_c = sum_c[MAG_W-1:0];
    end
    res_c  = neg4_r ? -$signed(mag_c) : $signed(mag_c);
    v5_nxt = rdy5 ? v4_r : v5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v5_nxt;
    end
    if (rdy5) begin
      res5_r <= res_c;
    end
  end

  assign out_valid  = v5_r;
  assign out_sample = res5_r;

endmodule

@@ hdl/interpolated_lut_waveshaper.sv @@
// Top level of the interpolated curve-table waveshaper.
//
//   Channel | Direction | Ports                                         | Word
//   in_     | input     | in_valid, in_stall, in_cmd, in_table_index,   | load or sample
//           |           | in_table_value, in_sample_in                  |
//   out_    | output    | out_valid, out_stall, out_sample_out          | shaped sample
//
// One word is accepted per clock while in_stall is low. A sample word passes
// through five pipeline registers, the last being the output register; the
// scale multiply, the registered table read and the interpolation multiply
// each have a stage of their own.
// A load word writes the table and produces no output word.
// Reset (rst_n low, synchronous) clears every stage valid bit; table contents
// are undefined until loaded. A stall only backs up as far as the first stage
// that holds a bubble, so in_stall rises only when every stage is full.
module interpolated_lut_waveshaper
  import ilw_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_cmd,
  input  logic [8:0]              in_table_index,
  input  logic [VAL_W-1:0]        in_table_value,
  input  logic signed [17:0]      in_sample_in,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [MAG_W-1:0] out_sample_out
);

  // Handshake between the scaling stages and the table stage.
  logic        sc_valid, sc_rdy;
  scale_word_t sc_word;
  // Handshake between the table stage and the interpolator.
  logic        tb_valid, tb_rdy;
  tbl_word_t   tb_word;
  logic        in_rdy;

  assign in_stall = !in_rdy;

  // Clamp the sample, take its magnitude and turn it into index and fraction.
  ilw_scale u_scale (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (in_valid),
    .up_rdy      (in_rdy),
    .cmd         (in_cmd),
    .table_index (in_table_index),
    .table_value (in_table_value),
    .sample_in   (in_sample_in),
    .dn_valid    (sc_valid),
    .dn_rdy      (sc_rdy),
    .dn_word     (sc_word)
  );

  // Loads are written in order with the reads, so a sample always sees
  // every load that was accepted ahead of it.
  ilw_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sc_valid),
    .up_rdy   (sc_rdy),
    .up_word  (sc_word),
    .dn_valid (tb_valid),
    .dn_rdy   (tb_rdy),
    .dn_word  (tb_word)
  );

  // Interpolate between the two neighbors, saturate and restore the sign.
  ilw_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (tb_valid),
    .up_rdy     (tb_rdy),
    .up_word    (tb_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample_out)
  );

  // The input can only be held off when the output is held off.
  a_stall_source : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_stall)
    else $error("input stalled while the output is free");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present right after reset");

  // The shaped sample stays within plus or minus one.
  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_out <= 17'sd32768 && out_sample_out >= -17'sd32768))
    else $error("output sample beyond full scale");

endmodule
